// ===== rtl/spa_pkg.sv =====
// Slot pool allocator package: request and response words, command and status codes.
// Standalone; imported by the top level.
`default_nettype none
package spa_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int OWNER_BITS = 3;

	localparam int SLOT_FW   = $clog2(SLOT_COUNT);
	localparam int OWNER_FW  = OWNER_BITS;
	localparam int CURSOR_FW = $clog2(SLOT_COUNT + 1);
	localparam int COUNT_FW  = $clog2(SLOT_COUNT + 1);

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_FIND  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_NONE   = 2'd1,
		STS_BUSY   = 2'd2,
		STS_UNUSED = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [SLOT_FW-1:0]   slot_index;
		logic                 pick_any;
		logic [OWNER_FW-1:0]  owner_id;
		logic                 filter_off;
		logic [CURSOR_FW-1:0] cursor_in;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [SLOT_FW-1:0]   result_slot;
		logic [CURSOR_FW-1:0] cursor_out;
		logic [COUNT_FW-1:0]  live_count;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/spa_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module spa_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/slot_pool_allocator_with_find_list_top.sv =====
// Slot pool allocator top level: used flags, owner RAM and a compact live list RAM.
// Depends on spa_pkg and spa_ram.
// One word at a time. Allocate of a given slot, clear and rejected words go straight to
// the response state. Allocate of any slot: scans the used flags, one used flag per cycle.
// Free: list RAM read, compare, shift back one entry per cycle.
// Find: walks the list (list RAM then owner RAM read per position).
// Reset clears the used flags, live count and handshake state; no clearing pass.
`default_nettype none
module slot_pool_allocator_with_find_list_top
	import spa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_FREE = 5'b00100,
		S_FIND = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t                state_q, state_d;
	logic [SLOT_COUNT-1:0] used_q;
	logic [CNT_W-1:0]      total_q;
	logic [IDX_W-1:0]      scan_q;
	logic [CNT_W-1:0]      rd_ptr_q;
	logic                  found_q;
	logic                  v_s1, v_s2;
	logic [IDX_W-1:0]      pos_s1, pos_s2, slot_s2;
	logic [IDX_W-1:0]      slot_q;
	logic [OWNER_BITS-1:0] want_q, owner_q;
	logic                  any_q;
	status_t               rsp_status_q;
	logic [IDX_W-1:0]      rsp_slot_q, rsp_cursor_q;
	logic                  out_valid_q;
	rsp_t                  out_q;

	logic [IDX_W-1:0]      req_idx;
	logic [OWNER_BITS-1:0] req_owner;
	logic                  req_in_range;
	logic                  find_past;
	logic [CNT_W-1:0]      find_pos0;
	logic                  issue, walk_empty, find_hit, shift_en, hit_now;
	logic                  rsp_set, out_load;
	status_t               rsp_status_d;
	logic [IDX_W-1:0]      rsp_slot_d, rsp_cursor_d;
	logic                  alloc_commit, scan_start, free_start, find_start, clear_all, free_done;
	logic [IDX_W-1:0]      commit_slot;

	logic                  list_we;
	logic [IDX_W-1:0]      list_waddr, list_wdata, list_rdata;
	logic [OWNER_BITS-1:0] owner_wdata, owner_rdata;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign req_idx      = IDX_W'(req.slot_index);
	assign req_owner    = OWNER_BITS'(req.owner_id);
	assign req_in_range = (32'(req.slot_index) < SLOT_COUNT);
	assign find_past    = (32'(req.cursor_in) >= 32'(total_q)) &&
	                      (32'(req.cursor_in) != SLOT_COUNT);
	assign find_pos0    = (32'(req.cursor_in) == SLOT_COUNT) ? '0 :
	                      CNT_W'(32'(req.cursor_in) + 32'd1);

	assign issue      = ((state_q == S_FREE) || (state_q == S_FIND)) && (rd_ptr_q < total_q);
	assign walk_empty = (rd_ptr_q >= total_q) && !v_s1 && !v_s2;
	assign find_hit   = v_s2 && (state_q == S_FIND) && (any_q || (owner_rdata == want_q));
	assign shift_en   = v_s1 && (state_q == S_FREE) && found_q;
	assign hit_now    = v_s1 && (state_q == S_FREE) && !found_q && (list_rdata == slot_q);
	assign out_load   = (state_q == S_RESP) && (!out_valid_q || rsp_ready);

	always_comb begin
		state_d      = state_q;
		rsp_set      = 1'b0;
		rsp_status_d = STS_OK;
		rsp_slot_d   = '0;
		rsp_cursor_d = '0;
		alloc_commit = 1'b0;
		commit_slot  = req_idx;
		scan_start   = 1'b0;
		free_start   = 1'b0;
		find_start   = 1'b0;
		clear_all    = 1'b0;
		free_done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (req.cmd)
						CMD_ALLOC: begin
							if (req.pick_any) begin
								scan_start = 1'b1;
								state_d    = S_SCAN;
							end else if (!req_in_range) begin
								rsp_set      = 1'b1;
								rsp_status_d = STS_NONE;
							end else if (used_q[req_idx]) begin
								rsp_set      = 1'b1;
								rsp_status_d = STS_BUSY;
							end else begin
								alloc_commit = 1'b1;
								rsp_set      = 1'b1;
								rsp_slot_d   = req_idx;
							end
						end
						CMD_FREE: begin
							if (!req_in_range || !used_q[req_idx]) begin
								rsp_set      = 1'b1;
								rsp_status_d = STS_UNUSED;
							end else begin
								free_start = 1'b1;
								state_d    = S_FREE;
							end
						end
						CMD_FIND: begin
							if (find_past) begin
								rsp_set      = 1'b1;
								rsp_status_d = STS_NONE;
							end else begin
								find_start = 1'b1;
								state_d    = S_FIND;
							end
						end
						CMD_CLEAR: begin
							clear_all = 1'b1;
							rsp_set   = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				commit_slot = scan_q;
				if (!used_q[scan_q]) begin
					alloc_commit = 1'b1;
					rsp_set      = 1'b1;
					rsp_slot_d   = scan_q;
				end else if (scan_q == LAST_IDX) begin
					rsp_set      = 1'b1;
					rsp_status_d = STS_NONE;
				end
			end
			S_FREE: begin
				if (walk_empty) begin
					free_done  = 1'b1;
					rsp_set    = 1'b1;
					rsp_slot_d = slot_q;
				end
			end
			S_FIND: begin
				if (find_hit) begin
					rsp_set      = 1'b1;
					rsp_slot_d   = slot_s2;
					rsp_cursor_d = pos_s2;
				end else if (walk_empty) begin
					rsp_set      = 1'b1;
					rsp_status_d = STS_NONE;
				end
			end
			S_RESP: begin
				if (!out_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (rsp_set) begin
			state_d = S_RESP;
		end
	end

	always_comb begin
		list_we     = alloc_commit || shift_en;
		list_waddr  = alloc_commit ? total_q[IDX_W-1:0] : (pos_s1 - IDX_W'(1));
		list_wdata  = alloc_commit ? commit_slot : list_rdata;
		owner_wdata = (state_q == S_SCAN) ? owner_q : req_owner;
	end

	spa_ram #(
		.DEPTH (SLOT_COUNT),
		.WIDTH (IDX_W)
	) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.raddr (rd_ptr_q[IDX_W-1:0]),
		.rdata (list_rdata)
	);

	spa_ram #(
		.DEPTH (SLOT_COUNT),
		.WIDTH (OWNER_BITS)
	) u_owner_ram (
		.clk   (clk),
		.we    (alloc_commit),
		.waddr (commit_slot),
		.wdata (owner_wdata),
		.raddr (list_rdata),
		.rdata (owner_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			total_q     <= '0;
			scan_q      <= '0;
			rd_ptr_q    <= '0;
			found_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1 && (state_q == S_FIND);
			if (clear_all) begin
				used_q  <= '0;
				total_q <= '0;
			end else if (alloc_commit) begin
				used_q[commit_slot] <= 1'b1;
				total_q             <= total_q + CNT_W'(1);
			end else if (free_start) begin
				used_q[req_idx] <= 1'b0;
			end else if (free_done) begin
				total_q <= total_q - CNT_W'(1);
			end
			if (scan_start) begin
				scan_q <= '0;
			end else if (state_q == S_SCAN) begin
				scan_q <= scan_q + IDX_W'(1);
			end
			if (free_start) begin
				rd_ptr_q <= '0;
			end else if (find_start) begin
				rd_ptr_q <= find_pos0;
			end else if (issue) begin
				rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			end
			if (free_start) begin
				found_q <= 1'b0;
			end else if (hit_now) begin
				found_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1  <= rd_ptr_q[IDX_W-1:0];
		pos_s2  <= pos_s1;
		slot_s2 <= list_rdata;
		if (req_valid && req_ready) begin
			slot_q  <= req_idx;
			want_q  <= req_owner;
			owner_q <= req_owner;
			any_q   <= req.filter_off;
		end
		if (rsp_set) begin
			rsp_status_q <= rsp_status_d;
			rsp_slot_q   <= rsp_slot_d;
			rsp_cursor_q <= rsp_cursor_d;
		end
		if (out_load) begin
			out_q.status      <= rsp_status_q;
			out_q.result_slot <= SLOT_FW'(rsp_slot_q);
			out_q.cursor_out  <= CURSOR_FW'(rsp_cursor_q);
			out_q.live_count  <= COUNT_FW'(total_q);
		end
	end

endmodule
`default_nettype wire
